/* rtl/core/hall_bldc_commutation_supervisor_assert.svh */
`ifndef HALL_BLDC_COMMUTATION_SUPERVISOR_ASSERT_SVH
`define HALL_BLDC_COMMUTATION_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HBCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hbcs_pkg.sv */
package hbcs_pkg;

  typedef struct packed {
    logic       run_open;
    logic [2:0] hall;
    logic       gate_ok;
    logic       trip_line_high;
    logic       trip_edge;
    logic [9:0] speed_sample;
  } in_req_t;

  typedef struct packed {
    logic [2:0] phase_enable;
    logic [1:0] pwm_phase;
    logic [5:0] pwm_duty;
    logic       driver_enable;
    logic       fault_led;
    logic       is_running;
  } out_rsp_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_VALID_MASK  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEXT_HALL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_PHASE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOW_PHASE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STALL_LIMIT = 3'd4;

  localparam logic [7:0]  VALID_MASK_RST  = 8'd126;
  localparam logic [15:0] STALL_LIMIT_RST = 16'd2000;
  localparam logic [15:0] STILL_MAX       = 16'hFFFF;
  localparam logic [7:0]  DUTY_NONE       = 8'd255;
  localparam logic [1:0]  PWM_NONE        = 2'd3;

  function automatic logic [2:0] tbl_entry(input logic [CfgDataW-1:0] tbl,
                                           input logic [2:0] idx);
    tbl_entry = tbl[3*idx +: 3];
  endfunction

endpackage

/* rtl/core/hall_bldc_commutation_supervisor.sv */
// Six-step hall-sensored BLDC commutation supervisor.
// Input channel: one control tick per request (in_req_i) with RUN level, hall
// code, gate status, trip level, trip edge and speed ADC sample; accepted when
// in_valid_i is high and in_stall_o is low.
// Output channel: one result per tick (out_rsp_o) with bridge enables, PWM
// phase, duty, driver enable, fault LED and running flag; taken when
// out_valid_o is high and out_stall_i is low.
// The result is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per cycle while the receiver does not stall; all
// tick logic sits between the state registers and the result register.
// A stalled receiver holds the result register; a new tick is then accepted
// only in the cycle the held result is taken.
// Configuration: cfg_we_i writes register cfg_idx_i (0 valid hall mask,
// 1 next hall table, 2 high phase table, 3 low phase table, 4 stall limit);
// other indexes are ignored. Write only while no tick is in flight.
// Reset: asynchronous, drops the output valid and restores all
// supervisor state and configuration defaults; the block starts unreleased.
module hall_bldc_commutation_supervisor #(
  parameter int unsigned SAMPLE_PERIOD = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hbcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hbcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hbcs_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hbcs_pkg::out_rsp_t             out_rsp_o
);
  import hbcs_pkg::*;

`include "hall_bldc_commutation_supervisor_assert.svh"

  localparam int unsigned CntW = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;

  logic [7:0]          valid_mask_q;
  logic [CfgDataW-1:0] next_tbl_q, high_tbl_q, low_tbl_q;
  logic [15:0]         stall_limit_q;

  logic            released_q, running_q, fault_q, armed_q, drv_q, led_q;
  logic            released_d, running_d, fault_d, armed_d, drv_d, led_d;
  logic [2:0]      last_hall_q, last_hall_d;
  logic [5:0]      duty_q, duty_d;
  logic [7:0]      prev_duty_q, prev_duty_d;
  logic [CntW-1:0] scnt_q, scnt_d;
  logic [15:0]     still_q, still_d;
  logic [2:0]      en_q, en_d;
  logic [1:0]      pwm_q, pwm_d;

  logic     out_valid_q;
  out_rsp_t out_q, out_d;
  logic     in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_mask_q  <= VALID_MASK_RST;
      next_tbl_q    <= '0;
      high_tbl_q    <= '0;
      low_tbl_q     <= '0;
      stall_limit_q <= STALL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VALID_MASK:  valid_mask_q  <= cfg_wdata_i[7:0];
        CFG_NEXT_HALL:   next_tbl_q    <= cfg_wdata_i;
        CFG_HIGH_PHASE:  high_tbl_q    <= cfg_wdata_i;
        CFG_LOW_PHASE:   low_tbl_q     <= cfg_wdata_i;
        CFG_STALL_LIMIT: stall_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic            hall_ok;
    logic [CntW:0]   scnt_inc;
    logic [2:0]      hi, lo;
    logic [7:0]      duty_ext;

    released_d  = released_q;
    running_d   = running_q;
    fault_d     = fault_q;
    armed_d     = armed_q;
    drv_d       = drv_q;
    led_d       = led_q;
    last_hall_d = last_hall_q;
    duty_d      = duty_q;
    prev_duty_d = prev_duty_q;
    scnt_d      = scnt_q;
    still_d     = still_q;
    en_d        = en_q;
    pwm_d       = pwm_q;
    duty_ext    = {2'b00, duty_q};
    hall_ok     = valid_mask_q[in_req_i.hall];
    scnt_inc    = {1'b0, scnt_q} + (CntW+1)'(1);
    hi          = tbl_entry(high_tbl_q, in_req_i.hall);
    lo          = tbl_entry(low_tbl_q, in_req_i.hall);

    if (armed_q && in_req_i.trip_edge) begin
      en_d    = '0;
      drv_d   = 1'b0;
      fault_d = 1'b1;
    end

    if (in_req_i.run_open) begin
      en_d       = '0;
      drv_d      = 1'b0;
      armed_d    = 1'b0;
      running_d  = 1'b0;
      fault_d    = 1'b0;
      released_d = 1'b1;
      led_d      = 1'b0;
    end else if (!running_d && released_d && !fault_d) begin
      released_d = 1'b0;
      drv_d      = 1'b1;
      if (!in_req_i.gate_ok || !in_req_i.trip_line_high || !hall_ok) begin
        fault_d = 1'b1;
        en_d    = '0;
        drv_d   = 1'b0;
      end else begin
        armed_d     = 1'b1;
        running_d   = 1'b1;
        last_hall_d = in_req_i.hall;
        still_d     = '0;
        prev_duty_d = DUTY_NONE;
      end
    end

    if (running_d && !fault_d) begin
      if (!in_req_i.gate_ok || !hall_ok ||
          (in_req_i.hall != last_hall_d &&
           in_req_i.hall != tbl_entry(next_tbl_q, last_hall_d))) begin
        fault_d = 1'b1;
      end
      if (scnt_inc >= (CntW+1)'(SAMPLE_PERIOD)) begin
        scnt_d = '0;
        duty_d = (in_req_i.speed_sample[9:6] == '0) ? '0 : in_req_i.speed_sample[9:4];
      end else begin
        scnt_d = scnt_inc[CntW-1:0];
      end
      if (in_req_i.hall != last_hall_d || duty_d == '0) begin
        still_d = '0;
      end else begin
        if (still_d != STILL_MAX) begin
          still_d = still_d + 16'd1;
        end
        if (still_d >= stall_limit_q) begin
          fault_d = 1'b1;
        end
      end
      duty_ext = {2'b00, duty_d};
      if (fault_d) begin
        en_d  = '0;
        drv_d = 1'b0;
      end else if (in_req_i.hall != last_hall_d || duty_ext != prev_duty_d) begin
        en_d  = '0;
        pwm_d = PWM_NONE;
        if (hall_ok && duty_d != '0) begin
          if (hi <= 3'd2) begin
            pwm_d = hi[1:0];
          end
          for (int p = 0; p < 3; p++) begin
            en_d[p] = (hi == 3'(p)) || (lo == 3'(p));
          end
        end
      end
      last_hall_d = in_req_i.hall;
      prev_duty_d = duty_ext;
    end

    if (fault_d) begin
      en_d  = '0;
      drv_d = 1'b0;
      led_d = 1'b1;
    end

    out_d.phase_enable  = en_d;
    out_d.pwm_phase     = pwm_d;
    out_d.pwm_duty      = duty_d;
    out_d.driver_enable = drv_d;
    out_d.fault_led     = led_d;
    out_d.is_running    = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      released_q  <= 1'b0;
      running_q   <= 1'b0;
      fault_q     <= 1'b0;
      armed_q     <= 1'b0;
      drv_q       <= 1'b0;
      led_q       <= 1'b0;
      last_hall_q <= '0;
      duty_q      <= '0;
      prev_duty_q <= DUTY_NONE;
      scnt_q      <= '0;
      still_q     <= '0;
      en_q        <= '0;
      pwm_q       <= PWM_NONE;
    end else if (in_acc) begin
      released_q  <= released_d;
      running_q   <= running_d;
      fault_q     <= fault_d;
      armed_q     <= armed_d;
      drv_q       <= drv_d;
      led_q       <= led_d;
      last_hall_q <= last_hall_d;
      duty_q      <= duty_d;
      prev_duty_q <= prev_duty_d;
      scnt_q      <= scnt_d;
      still_q     <= still_d;
      en_q        <= en_d;
      pwm_q       <= pwm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  `HBCS_ASSERT_NOW(a_fault_shuts_bridge, clk_i, rst_ni, fault_q,
                   (en_q == '0) && !drv_q, "fault left bridge powered")
  `HBCS_ASSERT_NOW(a_run_has_driver, clk_i, rst_ni, running_q && !fault_q,
                   drv_q, "running without gate driver")
  `HBCS_ASSERT_NOW(a_led_result_off, clk_i, rst_ni, out_valid_q && out_q.fault_led,
                   !out_q.driver_enable && (out_q.phase_enable == '0),
                   "fault result drives bridge")
  `HBCS_ASSERT_NEXT(a_open_stops, clk_i, rst_ni, in_acc && in_req_i.run_open,
                    out_valid_q && !out_q.is_running && !out_q.fault_led,
                    "open RUN did not stop the motor")

endmodule

/* dv/hall_bldc_commutation_supervisor_test.sv */
`timescale 1ns / 100ps

module hall_bldc_commutation_supervisor_test;
  import hbcs_pkg::*;

  localparam int unsigned SamplePeriod = 16;
  localparam logic [9:0] DUTY_FLOOR = 10'd64;
  localparam logic [17:0] HALL_SEQ = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
  localparam logic [17:0] HIGH_SEQ = {3'd2, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0};
  localparam logic [17:0] LOW_SEQ  = {3'd1, 3'd0, 3'd0, 3'd2, 3'd2, 3'd1};

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  in_req_t           in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_rsp_t          out_rsp_o;

  hall_bldc_commutation_supervisor #(
    .SAMPLE_PERIOD(SamplePeriod)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Supervisor mirror: configuration
  logic [7:0]          hall_mask;
  logic [CfgDataW-1:0] next_hall_tbl;
  logic [CfgDataW-1:0] high_tbl;
  logic [CfgDataW-1:0] low_tbl;
  logic [15:0]         stall_limit;

  // Supervisor mirror: state
  logic        sup_released, sup_running, sup_fault, sup_armed, sup_driver, sup_led;
  logic [2:0]  sup_last_hall;
  logic [5:0]  sup_duty;
  logic [7:0]  sup_prev_duty;
  logic [7:0]  sup_sample_cnt;
  logic [15:0] sup_still_cnt;
  logic [2:0]  sup_enables;
  logic [1:0]  sup_pwm;

  out_rsp_t expected_status[$];
  out_rsp_t want;
  int       fail_count;
  int       send_idle_pct;
  int       recv_idle_pct;

  function automatic logic [2:0] hall_field(logic [CfgDataW-1:0] tbl, logic [2:0] h);
    return tbl[3*h +: 3];
  endfunction

  function automatic logic hall_valid(logic [2:0] h);
    return hall_mask[h];
  endfunction

  function automatic in_req_t make_req(logic run_open, logic [2:0] hall, logic gate_ok,
                                       logic line_high, logic edge_seen, logic [9:0] speed);
    in_req_t r;
    r.run_open       = run_open;
    r.hall           = hall;
    r.gate_ok        = gate_ok;
    r.trip_line_high = line_high;
    r.trip_edge      = edge_seen;
    r.speed_sample   = speed;
    return r;
  endfunction

  task automatic reset_supervisor();
    hall_mask      = VALID_MASK_RST;
    next_hall_tbl  = '0;
    high_tbl       = '0;
    low_tbl        = '0;
    stall_limit    = STALL_LIMIT_RST;
    sup_released   = 1'b0;
    sup_running    = 1'b0;
    sup_fault      = 1'b0;
    sup_armed      = 1'b0;
    sup_driver     = 1'b0;
    sup_led        = 1'b0;
    sup_last_hall  = '0;
    sup_duty       = '0;
    sup_prev_duty  = DUTY_NONE;
    sup_sample_cnt = '0;
    sup_still_cnt  = '0;
    sup_enables    = '0;
    sup_pwm        = PWM_NONE;
  endtask

  function automatic out_rsp_t supervise_tick(in_req_t r);
    out_rsp_t   s;
    logic [2:0] hi;
    logic [2:0] lo;
    if (sup_armed && r.trip_edge) begin
      sup_enables = '0;
      sup_driver  = 1'b0;
      sup_fault   = 1'b1;
    end
    if (r.run_open) begin
      sup_enables  = '0;
      sup_driver   = 1'b0;
      sup_armed    = 1'b0;
      sup_running  = 1'b0;
      sup_fault    = 1'b0;
      sup_released = 1'b1;
      sup_led      = 1'b0;
    end else if (!sup_running && sup_released && !sup_fault) begin
      sup_released = 1'b0;
      sup_driver   = 1'b1;
      if (!r.gate_ok || !r.trip_line_high || !hall_valid(r.hall)) begin
        sup_fault   = 1'b1;
        sup_enables = '0;
        sup_driver  = 1'b0;
      end else begin
        sup_armed     = 1'b1;
        sup_running   = 1'b1;
        sup_last_hall = r.hall;
        sup_still_cnt = '0;
        sup_prev_duty = DUTY_NONE;
      end
    end
    if (sup_running && !sup_fault) begin
      if (!r.gate_ok || !hall_valid(r.hall) ||
          (r.hall != sup_last_hall && r.hall != hall_field(next_hall_tbl, sup_last_hall)))
        sup_fault = 1'b1;
      sup_sample_cnt = sup_sample_cnt + 8'd1;
      if (sup_sample_cnt >= SamplePeriod) begin
        sup_sample_cnt = '0;
        sup_duty = (r.speed_sample < DUTY_FLOOR) ? 6'd0 : r.speed_sample[9:4];
      end
      if (r.hall != sup_last_hall || sup_duty == 6'd0) begin
        sup_still_cnt = '0;
      end else begin
        if (sup_still_cnt != STILL_MAX) sup_still_cnt = sup_still_cnt + 16'd1;
        if (sup_still_cnt >= stall_limit) sup_fault = 1'b1;
      end
      if (sup_fault) begin
        sup_enables = '0;
        sup_driver  = 1'b0;
      end else if (r.hall != sup_last_hall || {2'b00, sup_duty} != sup_prev_duty) begin
        sup_enables = '0;
        sup_pwm     = PWM_NONE;
        if (hall_valid(r.hall) && sup_duty != 6'd0) begin
          hi = hall_field(high_tbl, r.hall);
          lo = hall_field(low_tbl, r.hall);
          if (hi <= 3'd2) sup_pwm = hi[1:0];
          for (int p = 0; p < 3; p++)
            if (hi == p || lo == p) sup_enables[p] = 1'b1;
        end
      end
      sup_last_hall = r.hall;
      sup_prev_duty = {2'b00, sup_duty};
    end
    if (sup_fault) begin
      sup_enables = '0;
      sup_driver  = 1'b0;
      sup_led     = 1'b1;
    end
    s.phase_enable  = sup_enables;
    s.pwm_phase     = sup_pwm;
    s.pwm_duty      = sup_duty;
    s.driver_enable = sup_driver;
    s.fault_led     = sup_led;
    s.is_running    = sup_running;
    return s;
  endfunction

  // Call at a falling edge; returns at a falling edge.
  task automatic send_tick(in_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = r;
    do @(posedge clk_i); while (in_stall_o);
    expected_status.push_back(supervise_tick(r));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_status.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_VALID_MASK:  hall_mask     = data[7:0];
      CFG_NEXT_HALL:   next_hall_tbl = data;
      CFG_HIGH_PHASE:  high_tbl      = data;
      CFG_LOW_PHASE:   low_tbl       = data;
      CFG_STALL_LIMIT: stall_limit   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic program_tables(logic [7:0] mask, logic [CfgDataW-1:0] nxt,
                                logic [CfgDataW-1:0] hi, logic [CfgDataW-1:0] lo,
                                logic [15:0] limit);
    write_reg(CFG_VALID_MASK, {16'd0, mask});
    write_reg(CFG_NEXT_HALL, nxt);
    write_reg(CFG_HIGH_PHASE, hi);
    write_reg(CFG_LOW_PHASE, lo);
    write_reg(CFG_STALL_LIMIT, {8'd0, limit});
  endtask

  task automatic program_six_step(logic reverse, logic [7:0] mask, logic [15:0] limit);
    logic [CfgDataW-1:0] nxt;
    logic [CfgDataW-1:0] hi;
    logic [CfgDataW-1:0] lo;
    logic [2:0]          code;
    nxt = '0;
    hi  = '1;
    lo  = '1;
    for (int i = 0; i < 6; i++) begin
      code = HALL_SEQ[3*i +: 3];
      nxt[3*code +: 3] = reverse ? HALL_SEQ[3*((i + 5) % 6) +: 3] :
                                   HALL_SEQ[3*((i + 1) % 6) +: 3];
      hi[3*code +: 3] = HIGH_SEQ[3*i +: 3];
      lo[3*code +: 3] = LOW_SEQ[3*i +: 3];
    end
    program_tables(mask, nxt, hi, lo, limit);
  endtask

  function automatic logic [2:0] pick_valid_hall();
    logic [2:0] h;
    for (int t = 0; t < 8; t++) begin
      h = 3'($urandom_range(7));
      if (hall_mask[h]) return h;
    end
    return h;
  endfunction

  function automatic logic [9:0] pick_speed();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(3))
        0: return 10'd0;
        1: return DUTY_FLOOR - 10'd1;
        2: return DUTY_FLOOR;
        default: return 10'h3FF;
      endcase
    end
    if (roll < 20) return 10'($urandom_range(0, 63));
    if (roll < 85) return 10'($urandom_range(64, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Runs of well-formed rotation with noise; RUN opens at the start of each run.
  task automatic run_random_ticks(int n);
    in_req_t    r;
    int         run_left;
    int         roll;
    logic [2:0] rotor_hall;
    run_left   = 0;
    rotor_hall = pick_valid_hall();
    for (int i = 0; i < n; i++) begin
      r = make_req(1'b0, rotor_hall, $urandom_range(99) >= 2, $urandom_range(99) >= 3,
                   $urandom_range(99) < 3, pick_speed());
      if (run_left == 0) begin
        r.run_open = 1'b1;
        run_left   = $urandom_range(10, 80);
        rotor_hall = pick_valid_hall();
        r.hall     = rotor_hall;
      end else begin
        run_left--;
        r.run_open = $urandom_range(99) < 2;
        roll = $urandom_range(99);
        if (roll >= 92) rotor_hall = 3'($urandom_range(7));
        else if (roll >= 65) rotor_hall = hall_field(next_hall_tbl, rotor_hall);
        r.hall = rotor_hall;
      end
      send_tick(r);
    end
  endtask

  task automatic test_release_checks();
    send_tick(make_req(1'b0, 3'd1, 1'b1, 1'b1, 1'b0, 10'h3FF));
    send_tick(make_req(1'b1, 3'd1, 1'b1, 1'b1, 1'b1, 10'h3FF));
    send_tick(make_req(1'b0, 3'd1, 1'b0, 1'b1, 1'b0, 10'h3FF));
    send_tick(make_req(1'b1, 3'd1, 1'b1, 1'b1, 1'b0, 10'd0));
    send_tick(make_req(1'b0, 3'd1, 1'b1, 1'b0, 1'b0, 10'd0));
    send_tick(make_req(1'b1, 3'd1, 1'b1, 1'b1, 1'b0, 10'd0));
    send_tick(make_req(1'b0, 3'd0, 1'b1, 1'b1, 1'b0, 10'd0));
    drain();
  endtask

  task automatic test_rotation_and_stall();
    program_six_step(1'b0, VALID_MASK_RST, 16'd1);
    for (int idx = CFG_STALL_LIMIT + 1; idx < 2**CfgIdxW; idx++)
      write_reg(CfgIdxW'(idx), CfgDataW'($urandom));
    send_tick(make_req(1'b1, 3'd1, 1'b1, 1'b1, 1'b0, 10'h3FF));
    send_tick(make_req(1'b0, 3'd1, 1'b1, 1'b1, 1'b0, 10'h3FF));
    for (int i = 1; i <= 15; i++)
      send_tick(make_req(1'b0, HALL_SEQ[3*(i % 6) +: 3], 1'b1, 1'b1, 1'b0, 10'h3FF));
    // hold the rotor: one still tick at a stall limit of 1
    send_tick(make_req(1'b0, HALL_SEQ[3*(15 % 6) +: 3], 1'b1, 1'b1, 1'b0, 10'h3FF));
    drain();
  endtask

  task automatic test_trip_and_sequence();
    send_tick(make_req(1'b1, 3'd1, 1'b1, 1'b1, 1'b0, 10'd64));
    send_tick(make_req(1'b0, 3'd1, 1'b1, 1'b1, 1'b0, 10'd64));
    send_tick(make_req(1'b0, 3'd1, 1'b1, 1'b1, 1'b1, 10'd64));
    send_tick(make_req(1'b1, 3'd3, 1'b1, 1'b1, 1'b0, 10'd63));
    send_tick(make_req(1'b0, 3'd3, 1'b1, 1'b1, 1'b0, 10'd63));
    send_tick(make_req(1'b0, 3'd6, 1'b1, 1'b1, 1'b0, 10'd63));
    drain();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: program_six_step(1'b0, VALID_MASK_RST, 16'($urandom_range(1, 40)));
        1: program_tables(8'hFF, CfgDataW'($urandom), CfgDataW'($urandom),
                          CfgDataW'($urandom), 16'($urandom_range(1, 65535)));
        2: program_six_step(1'b1, 8'hFF, 16'hFFFF);
        default: program_tables((send_pct == 0) ? 8'h00 : 8'hFF, '1, '1, '0, 16'd1);
      endcase
      run_random_ticks(90);
      drain();
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL hall_bldc_commutation_supervisor");
    $finish;
  end

  always @(negedge clk_i)
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        $error("status result with no request outstanding");
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("phase_enable", want.phase_enable, out_rsp_o.phase_enable);
        check_field("pwm_phase", want.pwm_phase, out_rsp_o.pwm_phase);
        check_field("pwm_duty", want.pwm_duty, out_rsp_o.pwm_duty);
        check_field("driver_enable", want.driver_enable, out_rsp_o.driver_enable);
        check_field("fault_led", want.fault_led, out_rsp_o.fault_led);
        check_field("is_running", want.is_running, out_rsp_o.is_running);
      end
    end
  end

  initial begin
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    out_stall_i   = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    reset_supervisor();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_release_checks();
    test_rotation_and_stall();
    test_trip_and_sequence();
    test_random_traffic(16, 66);
    test_random_traffic(66, 16);
    test_random_traffic(0, 0);

    drain();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS hall_bldc_commutation_supervisor");
    end else begin
      $display("FAIL hall_bldc_commutation_supervisor");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hbcs_pkg.sv
rtl/core/hall_bldc_commutation_supervisor.sv
dv/hall_bldc_commutation_supervisor_test.sv
